@@ rtl/qosq_pkg.sv @@
package qosq_pkg;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_HEAD  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_SHIFT = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   localparam logic [1:0] MODE_PUSH = 2'd0;
   localparam logic [1:0] MODE_POP  = 2'd1;
   localparam logic [1:0] MODE_PEEK = 2'd2;
   localparam logic [1:0] MODE_TAKE = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

endpackage

@@ rtl/qosq_store.sv @@
module qosq_store #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 72
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/qos_priority_request_queue.sv @@
// Ordered request queue of up to DEPTH entries (payload plus QoS) held as a
// circular buffer in a single-port-read, single-port-write store. Each item
// gives exactly one result. A push, or any operation that fails on an empty
// or full queue, goes from idle straight to the done state and then to the
// output register; pop and peek pass through the head-read state first.
// Take-highest reads the entries one per cycle through the single read port
// and one comparator, then closes the gap one entry per cycle, then posts
// the result. req_stall is high until the result has been posted.
module qos_priority_request_queue
   import qosq_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 64,
   parameter int QOS_WIDTH  = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_mode,
   input  logic [DATA_WIDTH-1:0]        req_data_in,
   input  logic [QOS_WIDTH-1:0]         req_qos_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [DATA_WIDTH-1:0]        rsp_data_out,
   output logic [QOS_WIDTH-1:0]         rsp_qos_out,
   output logic                         rsp_data_valid,
   output logic [1:0]                   rsp_status,
   output logic                         rsp_queue_empty,
   output logic [$clog2(DEPTH+1)-1:0]   rsp_entry_count
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = DATA_WIDTH + QOS_WIDTH;

   function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [IW-1:0] b);
      logic [IW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (IW+1)'(DEPTH)) begin
         s = s - (IW+1)'(DEPTH);
      end
      return s[IW-1:0];
   endfunction

   state_type state_ff, state_in;
   logic [IW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] scan_ff, scan_in;
   logic [IW-1:0] best_ff, best_in;
   logic [IW-1:0] shift_ff, shift_in;
   logic [1:0] mode_ff, mode_in;

   logic [DATA_WIDTH-1:0] res_data_ff, res_data_in;
   logic [QOS_WIDTH-1:0] res_qos_ff, res_qos_in;
   logic res_valid_ff, res_valid_in;
   logic [1:0] res_status_ff, res_status_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic [QOS_WIDTH-1:0] rsp_qos_ff, rsp_qos_in;
   logic rsp_dv_ff, rsp_dv_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [CW-1:0] rsp_count_ff, rsp_count_in;

   logic wr_en, rd_en;
   logic [IW-1:0] wr_off, rd_off;
   logic [EW-1:0] wr_data, rd_data;
   logic [DATA_WIDTH-1:0] rd_payload;
   logic [QOS_WIDTH-1:0] rd_qos;
   logic req_accept;
   logic take_new;
   logic [IW-1:0] best_new;
   logic [IW-1:0] shift_next;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rd_payload = rd_data[EW-1:QOS_WIDTH];
   assign rd_qos     = rd_data[QOS_WIDTH-1:0];
   assign take_new   = (scan_ff == '0) || (rd_qos > res_qos_ff);
   assign best_new   = take_new ? scan_ff : best_ff;
   assign shift_next = shift_ff + 1'b1;

   qosq_store #(
      .DEPTH (DEPTH),
      .WIDTH (EW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wrap_add(head_ff, wr_off)),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (wrap_add(head_ff, rd_off)),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      best_in       = best_ff;
      shift_in      = shift_ff;
      mode_in       = mode_ff;
      res_data_in   = res_data_ff;
      res_qos_in    = res_qos_ff;
      res_valid_in  = res_valid_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      rsp_qos_in    = rsp_qos_ff;
      rsp_dv_in     = rsp_dv_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_off        = '0;
      wr_data       = {req_data_in, req_qos_in};
      rd_en         = 1'b0;
      rd_off        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               mode_in       = req_mode;
               res_data_in   = '0;
               res_qos_in    = '0;
               res_valid_in  = 1'b0;
               res_status_in = STATUS_OK;
               scan_in       = '0;
               state_in      = ST_DONE;
               if (req_mode == MODE_PUSH) begin
                  if (count_ff == CW'(DEPTH)) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_off   = IW'(count_ff);
                     count_in = count_ff + 1'b1;
                  end
               end else if (count_ff == '0) begin
                  res_status_in = STATUS_EMPTY;
               end else begin
                  rd_en    = 1'b1;
                  rd_off   = '0;
                  state_in = (req_mode == MODE_TAKE) ? ST_SCAN : ST_HEAD;
               end
            end
         end
         ST_HEAD: begin
            res_data_in  = rd_payload;
            res_qos_in   = rd_qos;
            res_valid_in = 1'b1;
            if (mode_ff == MODE_POP) begin
               head_in  = wrap_add(head_ff, IW'(1));
               count_in = count_ff - 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            best_in = best_new;
            if (take_new) begin
               res_data_in = rd_payload;
               res_qos_in  = rd_qos;
            end
            if (CW'(scan_ff) + 1'b1 != count_ff) begin
               rd_en   = 1'b1;
               rd_off  = scan_ff + 1'b1;
               scan_in = scan_ff + 1'b1;
            end else begin
               res_valid_in = 1'b1;
               if (CW'(best_new) + 1'b1 == count_ff) begin
                  count_in = count_ff - 1'b1;
                  state_in = ST_DONE;
               end else begin
                  rd_en    = 1'b1;
                  rd_off   = best_new + 1'b1;
                  shift_in = best_new;
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            // entry at shift + 1 moves down one place
            wr_en   = 1'b1;
            wr_off  = shift_ff;
            wr_data = rd_data;
            if (CW'(shift_ff) + CW'(2) == count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_off   = shift_next + 1'b1;
               shift_in = shift_next;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res_data_ff;
               rsp_qos_in    = res_qos_ff;
               rsp_dv_in     = res_valid_ff;
               rsp_status_in = res_status_ff;
               rsp_count_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      best_ff       <= best_in;
      shift_ff      <= shift_in;
      mode_ff       <= mode_in;
      res_data_ff   <= res_data_in;
      res_qos_ff    <= res_qos_in;
      res_valid_ff  <= res_valid_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_qos_ff    <= rsp_qos_in;
      rsp_dv_ff     <= rsp_dv_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_qos_out     = rsp_qos_ff;
   assign rsp_data_valid  = rsp_dv_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_queue_empty = (rsp_count_ff == '0);
   assign rsp_entry_count = rsp_count_ff;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import qosq_pkg::*;

   localparam int QDEPTH     = 16;
   localparam int IDLE_LIMIT = 2000;
   localparam int HOLD_LEN   = 300;

   typedef struct packed {
      logic [1:0]  mode;
      logic [63:0] data;
      logic [7:0]  qos;
      logic        drain;
   } qreq_t;

   typedef struct packed {
      logic [63:0] payload;
      logic [7:0]  prio;
   } qentry_t;

   typedef struct packed {
      logic [63:0] data;
      logic [7:0]  qos;
      logic        data_valid;
      logic [1:0]  status;
      logic        empty;
      logic [4:0]  count;
   } qrsp_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode = MODE_PUSH;
   logic [63:0] req_data_in = '0;
   logic [7:0]  req_qos_in = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_data_out;
   logic [7:0]  rsp_qos_out;
   logic        rsp_data_valid;
   logic [1:0]  rsp_status;
   logic        rsp_queue_empty;
   logic [4:0]  rsp_entry_count;

   qreq_t   pending_req[$];
   qrsp_t   expected_rsp[$];
   qentry_t queued_entries[$];

   int fail_count = 0;
   int burst_left = 1;
   int gap_left = 0;
   int rsp_seen = 0;
   int hold_left = 0;
   int pat_cnt = 0;
   int stall_style = 0;
   int idle_cycles = 0;

   qos_priority_request_queue dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_data_in    (req_data_in),
      .req_qos_in     (req_qos_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data_out   (rsp_data_out),
      .rsp_qos_out    (rsp_qos_out),
      .rsp_data_valid (rsp_data_valid),
      .rsp_status     (rsp_status),
      .rsp_queue_empty(rsp_queue_empty),
      .rsp_entry_count(rsp_entry_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic qrsp_t apply_queue_op(qreq_t r);
      qrsp_t   res;
      qentry_t e;
      int      best;
      res = '0;
      res.status = STATUS_OK;
      case (r.mode)
         MODE_PUSH: begin
            if (queued_entries.size() >= QDEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               e.payload = r.data;
               e.prio = r.qos;
               queued_entries.push_back(e);
            end
         end
         MODE_POP, MODE_PEEK: begin
            if (queued_entries.size() == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.data = queued_entries[0].payload;
               res.qos = queued_entries[0].prio;
               res.data_valid = 1'b1;
               if (r.mode == MODE_POP) void'(queued_entries.pop_front());
            end
         end
         default: begin
            if (queued_entries.size() == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               best = 0;
               for (int i = 1; i < queued_entries.size(); i++) begin
                  if (queued_entries[i].prio > queued_entries[best].prio) best = i;
               end
               res.data = queued_entries[best].payload;
               res.qos = queued_entries[best].prio;
               res.data_valid = 1'b1;
               queued_entries.delete(best);
            end
         end
      endcase
      res.empty = (queued_entries.size() == 0);
      res.count = 5'(queued_entries.size());
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic queue_req(logic [1:0] mode, logic [63:0] data, logic [7:0] qos,
                            logic drain);
      qreq_t r;
      r.mode = mode;
      r.data = data;
      r.qos = qos;
      r.drain = drain;
      pending_req.push_back(r);
   endtask

   // sender: bursts and gaps, optional drain before an item
   always @(posedge clock) begin : drive_proc
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsp.push_back(apply_queue_op(pending_req.pop_front()));
         end
         if (!(req_valid && req_stall)) begin
            offer = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_req.size() > 0 &&
                         !(pending_req[0].drain && expected_rsp.size() > 0)) begin
               offer = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                            : $urandom_range(1, 12);
               end
            end
            req_valid <= offer;
            if (offer) begin
               req_mode <= pending_req[0].mode;
               req_data_in <= pending_req[0].data;
               req_qos_in <= pending_req[0].qos;
            end
         end
      end
   end

   // receiver: checks and its own stall pattern, with long hold-offs
   always @(posedge clock) begin : monitor_proc
      qrsp_t want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected item", rsp_data_out, '0);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data_out !== want.data)
                  report_mismatch("data_out", rsp_data_out, want.data);
               if (rsp_qos_out !== want.qos)
                  report_mismatch("qos_out", 64'(rsp_qos_out), 64'(want.qos));
               if (rsp_data_valid !== want.data_valid)
                  report_mismatch("data_valid", 64'(rsp_data_valid), 64'(want.data_valid));
               if (rsp_status !== want.status)
                  report_mismatch("status", 64'(rsp_status), 64'(want.status));
               if (rsp_queue_empty !== want.empty)
                  report_mismatch("queue_empty", 64'(rsp_queue_empty), 64'(want.empty));
               if (rsp_entry_count !== want.count)
                  report_mismatch("entry_count", 64'(rsp_entry_count), 64'(want.count));
            end
            rsp_seen++;
            if (rsp_seen == 400 || rsp_seen == 1200) hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            pat_cnt++;
            if (pat_cnt % 64 == 0) stall_style = $urandom_range(0, 3);
            case (stall_style)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= 1'($urandom_range(0, 1));
               2: rsp_stall <= (pat_cnt % 3 != 0);
               default: rsp_stall <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : watchdog_proc
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin : stim_proc
      int n;
      int seg_len;
      int push_pct;
      int qos_style;
      logic [1:0] m;
      logic [7:0] q;

      // empty queue corner cases
      queue_req(MODE_POP, '0, '0, 1'b0);
      queue_req(MODE_PEEK, '1, '1, 1'b0);
      queue_req(MODE_TAKE, '0, '0, 1'b0);
      // fill to full, with extremes and QoS ties
      queue_req(MODE_PUSH, '1, 8'd0, 1'b0);
      queue_req(MODE_PUSH, '0, 8'd255, 1'b0);
      queue_req(MODE_PUSH, 64'h5555_5555_5555_5555, 8'd255, 1'b0);
      queue_req(MODE_PUSH, 64'hAAAA_AAAA_AAAA_AAAA, 8'd170, 1'b0);
      for (int i = 0; i < 12; i++)
         queue_req(MODE_PUSH, {$urandom, $urandom}, 8'($urandom_range(0, 85)), 1'b0);
      queue_req(MODE_PUSH, '1, 8'd255, 1'b0);
      queue_req(MODE_PUSH, 64'h1234, 8'd1, 1'b0);
      queue_req(MODE_PEEK, '0, '0, 1'b0);
      queue_req(MODE_TAKE, '0, '0, 1'b0);
      queue_req(MODE_TAKE, '0, '0, 1'b0);
      queue_req(MODE_POP, '0, '0, 1'b0);
      queue_req(MODE_TAKE, '0, '0, 1'b0);

      n = 0;
      while (n < 1600) begin
         seg_len = $urandom_range(20, 80);
         case ($urandom_range(0, 2))
            0: push_pct = 85;
            1: push_pct = 50;
            default: push_pct = 20;
         endcase
         qos_style = $urandom_range(0, 3);
         for (int i = 0; i < seg_len; i++) begin
            if ($urandom_range(0, 99) < push_pct) begin
               m = MODE_PUSH;
            end else begin
               case ($urandom_range(0, 2))
                  0: m = MODE_POP;
                  1: m = MODE_PEEK;
                  default: m = MODE_TAKE;
               endcase
            end
            case (qos_style)
               0: q = 8'($urandom_range(0, 255));
               1: q = 8'($urandom_range(0, 3));
               2: q = '0;
               default: q = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'($urandom_range(250, 254));
            endcase
            queue_req(m, {$urandom, $urandom}, q,
                      (n == 0) || (i == 0 && $urandom_range(0, 4) == 0));
            n++;
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_req.size() > 0 || expected_rsp.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
